[rtl/hvd_pkg.sv]
`default_nettype none

package hvd_pkg;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int DIST_W = 32;
  localparam int RAD_W = 24;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int AW = 34;
  localparam int WW = 36;

  localparam logic signed [WW-1:0] QUARTER_W = 36'sd1800000000;
  localparam logic signed [WW-1:0] HALF_W = 36'sd3600000000;
  localparam logic signed [AW-1:0] QUARTER_A = 34'sd1800000000;
  localparam logic signed [AW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam int SQ_VW = 61;
  localparam int SQ_RW = 31;
  localparam int SQ_TW = 63;
  localparam logic [SQ_VW-1:0] ONE_Q60 = 61'h1000000000000000;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int MW = 50;
  localparam logic [86:0] RND_ADD = 87'd9663676416000000;

  // Dividing by 140625 is a multiplication by ceil(2^68 / 140625) and a
  // right shift by 68, exact for every dividend below 2^50.
  localparam int REC_W = 51;
  localparam int REC_SH = 68;
  localparam int QW = 33;
  localparam int DIV_ST = 3;
  localparam logic [REC_W-1:0] REC_M = 51'd2098829547942065;

  localparam logic [RAD_W-1:0] RADIUS_RST = 24'd6371000;
  localparam logic REG_RADIUS = 1'b0;

  typedef enum logic [1:0] {
    CORDIC_SIN,
    CORDIC_COS,
    CORDIC_ATAN
  } cordic_mode_t;

  typedef struct packed {
    logic neg;
    logic signed [AW-1:0] ang;
  } cos_arg_t;

  function automatic logic signed [AW-1:0] atan_u(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0: v = 34'sd900000000;
      1: v = 34'sd531301024;
      2: v = 34'sd280724869;
      3: v = 34'sd142500327;
      4: v = 34'sd71526687;
      5: v = 34'sd35798212;
      6: v = 34'sd17903474;
      7: v = 34'sd8952283;
      8: v = 34'sd4476210;
      9: v = 34'sd2238114;
      10: v = 34'sd1119058;
      11: v = 34'sd559529;
      12: v = 34'sd279765;
      13: v = 34'sd139882;
      14: v = 34'sd69941;
      15: v = 34'sd34971;
      16: v = 34'sd17485;
      17: v = 34'sd8743;
      18: v = 34'sd4371;
      19: v = 34'sd2186;
      20: v = 34'sd1093;
      21: v = 34'sd546;
      22: v = 34'sd273;
      23: v = 34'sd137;
      24: v = 34'sd68;
      25: v = 34'sd34;
      26: v = 34'sd17;
      27: v = 34'sd9;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      31: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Wraps a half difference into the range of minus to plus a quarter turn.
  function automatic logic signed [AW-1:0] wrap_half(input logic signed [WW-1:0] d);
    logic signed [WW-1:0] x;
    x = d + QUARTER_W;
    if (x >= HALF_W) begin
      x = x - HALF_W;
    end else if (x[WW-1]) begin
      x = x + HALF_W;
    end
    return AW'(x - QUARTER_W);
  endfunction

  // Latitudes past a quarter turn use the supplement with a negated cosine.
  function automatic cos_arg_t cos_prep(input logic signed [LAT_W-1:0] lat);
    logic signed [WW-1:0] t;
    cos_arg_t r;
    t = WW'(lat) <<< 1;
    if (t[WW-1]) begin
      t = -t;
    end
    if (t > QUARTER_W) begin
      r.neg = 1'b1;
      r.ang = AW'(HALF_W - t);
    end else begin
      r.neg = 1'b0;
      r.ang = AW'(t);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/hvd_cordic.sv]
`default_nettype none

module hvd_cordic #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF,
  parameter hvd_pkg::cordic_mode_t MODE = hvd_pkg::CORDIC_SIN
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [hvd_pkg::AW-1:0]  x_i,
  input  logic signed [hvd_pkg::AW-1:0]  y_i,
  input  logic signed [hvd_pkg::AW-1:0]  z_i,
  output logic signed [hvd_pkg::AW-1:0]  res_o
);
  import hvd_pkg::*;

  logic signed [AW-1:0] x_r [1:STAGES];
  logic signed [AW-1:0] y_r [1:STAGES];
  logic signed [AW-1:0] z_r [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic signed [AW-1:0] xc, yc, zc, dx, dy;
    logic dir;
    if (i == 0) begin : g_first
      assign xc = x_i;
      assign yc = y_i;
      assign zc = z_i;
    end else begin : g_next
      assign xc = x_r[i];
      assign yc = y_r[i];
      assign zc = z_r[i];
    end
    assign dx = yc >>> i;
    assign dy = xc >>> i;
    assign dir = (MODE == CORDIC_ATAN) ? yc[AW-1] : !zc[AW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (MODE == CORDIC_ATAN) begin
          if (!dir) begin
            x_r[i+1] <= xc + dx;
            y_r[i+1] <= yc - dy;
            z_r[i+1] <= zc + atan_u(i);
          end else begin
            x_r[i+1] <= xc - dx;
            y_r[i+1] <= yc + dy;
            z_r[i+1] <= zc - atan_u(i);
          end
        end else begin
          if (dir) begin
            x_r[i+1] <= xc - dx;
            y_r[i+1] <= yc + dy;
            z_r[i+1] <= zc - atan_u(i);
          end else begin
            x_r[i+1] <= xc + dx;
            y_r[i+1] <= yc - dy;
            z_r[i+1] <= zc + atan_u(i);
          end
        end
      end
    end
  end

  always_comb begin
    case (MODE)
      CORDIC_SIN: res_o = y_r[STAGES];
      CORDIC_COS: res_o = x_r[STAGES];
      default: res_o = z_r[STAGES];
    endcase
  end

endmodule

`default_nettype wire

[rtl/hvd_isqrt.sv]
`default_nettype none

module hvd_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hvd_pkg::SQ_VW-1:0]     v_i,
  output logic [hvd_pkg::SQ_RW-1:0]     root_o
);
  import hvd_pkg::*;

  logic [SQ_VW-1:0] r_r [1:SQ_RW];
  logic [SQ_RW-1:0] root_r [1:SQ_RW];

  for (genvar j = 0; j < SQ_RW; j++) begin : g_st
    localparam int K = SQ_RW - 1 - j;
    logic [SQ_VW-1:0] rc;
    logic [SQ_RW-1:0] rootc;
    logic [SQ_TW-1:0] trial;
    logic ge;
    if (j == 0) begin : g_first
      assign rc = v_i;
      assign rootc = '0;
    end else begin : g_next
      assign rc = r_r[j];
      assign rootc = root_r[j];
    end
    assign trial = (SQ_TW'(rootc) << (K + 1)) + (SQ_TW'(1) << (2 * K));
    assign ge = SQ_TW'(rc) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j+1] <= ge ? SQ_VW'(SQ_TW'(rc) - trial) : rc;
        root_r[j+1] <= ge ? (rootc | (SQ_RW'(1) << K)) : rootc;
      end
    end
  end

  assign root_o = root_r[SQ_RW];

endmodule

`default_nettype wire

[rtl/haversine_distance.sv]
// Great-circle distance between a previous and a current position.
// Input channel: in_valid/in_stall carry the four coordinates in degrees
// times 10^7. A request is taken at a rising edge with in_valid high and
// in_stall low. Output channel: out_valid/out_stall carry the distance in
// centimeters, one result per request, in request order.
// The earth radius in meters is written over the APB-style cfg_ port at
// byte address 0, by the user only while no request is in flight; the
// block itself does not enforce this. The depth from acceptance to out_valid
// comes from the two CORDIC chains (CORDIC_STAGES, 24 by default), the
// 31-step square root and a three-stage reciprocal multiplication for the
// unit conversion. One request can enter every cycle while in_stall is low.
// When the receiver stalls, a result waiting at the output is held and the
// next result is parked in a skid register; the pipeline stops and
// in_stall rises only once that skid register is full, so nothing is lost.
// Reset empties the pipeline and restores the radius to 6371000 m.
`default_nettype none

module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hvd_pkg::LAT_W-1:0]    in_prev_lat,
  input  logic signed [hvd_pkg::LON_W-1:0]    in_prev_lon,
  input  logic signed [hvd_pkg::LAT_W-1:0]    in_cur_lat,
  input  logic signed [hvd_pkg::LON_W-1:0]    in_cur_lon,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hvd_pkg::DIST_W-1:0]          out_distance_cm,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hvd_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [hvd_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [hvd_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready
);
  import hvd_pkg::*;

  localparam int S = CORDIC_STAGES;
  localparam int LAT = 2 * S + SQ_RW + 7 + DIV_ST;

  logic en, in_acc;
  logic [LAT-1:0] vld_r;
  logic [RAD_W-1:0] radius_r;

  assign en = !in_stall;
  assign in_acc = in_valid && !in_stall;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RADIUS) ? CFG_DW'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_RADIUS) begin
      radius_r <= cfg_pwdata[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  // Angle preparation.
  logic signed [WW-1:0] dlat, dlon;
  logic signed [AW-1:0] ang_s1_r, ang_s2_r, ang_cp_r, ang_cc_r;
  logic neg_p_r, neg_c_r;
  cos_arg_t cp_nxt, cc_nxt;

  assign dlat = WW'(in_cur_lat) - WW'(in_prev_lat);
  assign dlon = WW'(in_cur_lon) - WW'(in_prev_lon);
  assign cp_nxt = cos_prep(in_prev_lat);
  assign cc_nxt = cos_prep(in_cur_lat);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_s1_r <= wrap_half(dlat);
      ang_s2_r <= wrap_half(dlon);
      ang_cp_r <= cp_nxt.ang;
      neg_p_r <= cp_nxt.neg;
      ang_cc_r <= cc_nxt.ang;
      neg_c_r <= cc_nxt.neg;
    end
  end

  logic signed [AW-1:0] sin1_w, sin2_w, cosp_w, cosc_w;
  logic [S-1:0] negp_line_r, negc_line_r;

  hvd_cordic #(.STAGES(S), .MODE(CORDIC_SIN)) u_sin1 (
    .clk(clk), .en(en), .x_i(CORDIC_X0), .y_i('0), .z_i(ang_s1_r), .res_o(sin1_w)
  );
  hvd_cordic #(.STAGES(S), .MODE(CORDIC_SIN)) u_sin2 (
    .clk(clk), .en(en), .x_i(CORDIC_X0), .y_i('0), .z_i(ang_s2_r), .res_o(sin2_w)
  );
  hvd_cordic #(.STAGES(S), .MODE(CORDIC_COS)) u_cosp (
    .clk(clk), .en(en), .x_i(CORDIC_X0), .y_i('0), .z_i(ang_cp_r), .res_o(cosp_w)
  );
  hvd_cordic #(.STAGES(S), .MODE(CORDIC_COS)) u_cosc (
    .clk(clk), .en(en), .x_i(CORDIC_X0), .y_i('0), .z_i(ang_cc_r), .res_o(cosc_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      negp_line_r <= {negp_line_r[S-2:0], neg_p_r};
      negc_line_r <= {negc_line_r[S-2:0], neg_c_r};
    end
  end

  // Haversine term.
  logic signed [AW-1:0] cpa, cca;
  logic signed [31:0] s1_t, s2_t, cpa_t, cca_t, cp_t, sq_t;
  logic signed [63:0] p_s1_r, p_s2_r, p_cc_r, s1sq_r, p_h_r;
  logic signed [65:0] hav;
  logic [SQ_VW-1:0] ua_nxt, ua_r, ub_r;

  assign cpa = negp_line_r[S-1] ? -cosp_w : cosp_w;
  assign cca = negc_line_r[S-1] ? -cosc_w : cosc_w;
  assign s1_t = 32'(sin1_w);
  assign s2_t = 32'(sin2_w);
  assign cpa_t = 32'(cpa);
  assign cca_t = 32'(cca);
  assign cp_t = 32'(p_cc_r >>> 30);
  assign sq_t = 32'(p_s2_r >>> 30);
  assign hav = 66'(s1sq_r) + 66'(p_h_r);

  always_comb begin
    if (hav[65]) begin
      ua_nxt = '0;
    end else if (hav > 66'(ONE_Q60)) begin
      ua_nxt = ONE_Q60;
    end else begin
      ua_nxt = SQ_VW'(hav);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s1_r <= s1_t * s1_t;
      p_s2_r <= s2_t * s2_t;
      p_cc_r <= cpa_t * cca_t;
      s1sq_r <= p_s1_r;
      p_h_r <= cp_t * sq_t;
      ua_r <= ua_nxt;
      ub_r <= ONE_Q60 - ua_nxt;
    end
  end

  // Square roots and central angle.
  logic [SQ_RW-1:0] sa, sb;
  logic signed [AW-1:0] half_w;
  logic [S-1:0] nz_line_r;

  hvd_isqrt u_sqrt_a (.clk(clk), .en(en), .v_i(ua_r), .root_o(sa));
  hvd_isqrt u_sqrt_b (.clk(clk), .en(en), .v_i(ub_r), .root_o(sb));

  hvd_cordic #(.STAGES(S), .MODE(CORDIC_ATAN)) u_atan (
    .clk(clk), .en(en), .x_i(AW'(sb)), .y_i(AW'(sa)), .z_i('0), .res_o(half_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nz_line_r <= {nz_line_r[S-2:0], |sa};
    end
  end

  // Scaling to centimeters: round(R * h * PI_Q30 / (1.8e7 * 2^30)).
  logic [30:0] half;
  logic [54:0] prod_r;
  logic [59:0] lo_r;
  logic [58:0] hi_r;
  logic [86:0] n_sum;
  logic [MW-1:0] m_r;

  always_comb begin
    if (!nz_line_r[S-1] || half_w[AW-1]) begin
      half = '0;
    end else if (half_w > QUARTER_A) begin
      half = 31'(QUARTER_A);
    end else begin
      half = half_w[30:0];
    end
  end

  assign n_sum = (87'(hi_r) << 28) + 87'(lo_r) + RND_ADD;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 55'(radius_r) * 55'(half);
      lo_r <= 60'(prod_r[27:0]) * 60'(PI_Q30);
      hi_r <= 59'(prod_r[54:28]) * 59'(PI_Q30);
      m_r <= n_sum[86:37];
    end
  end

  // Quotient by 140625 as four partial products of the reciprocal.
  logic [50:0] pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r, pp_hh2_r, pp_ll2_r;
  logic [51:0] pp_mid_r;
  logic [100:0] q_full;
  logic [QW-1:0] q_r;

  assign q_full = (101'(pp_hh2_r) << 50) + (101'(pp_mid_r) << 25) + 101'(pp_ll2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= 51'(m_r[49:25]) * 51'(REC_M[50:25]);
      pp_hl_r <= 51'(m_r[49:25]) * 51'(REC_M[24:0]);
      pp_lh_r <= 51'(m_r[24:0]) * 51'(REC_M[50:25]);
      pp_ll_r <= 51'(m_r[24:0]) * 51'(REC_M[24:0]);
      pp_mid_r <= 52'(pp_hl_r) + 52'(pp_lh_r);
      pp_hh2_r <= pp_hh_r;
      pp_ll2_r <= pp_ll_r;
      q_r <= q_full[100:REC_SH];
    end
  end

  logic fin_v;
  logic [DIST_W-1:0] fin_d, o_r, s_r;
  logic ov_r, sv_r;

  assign fin_v = vld_r[LAT-1];
  assign fin_d = (|q_r[QW-1:DIST_W]) ? '1 : q_r[DIST_W-1:0];

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (!out_stall) begin
        o_r <= s_r;
        sv_r <= 1'b0;
      end
    end else if (ov_r && out_stall) begin
      if (fin_v) begin
        s_r <= fin_d;
        sv_r <= 1'b1;
      end
    end else begin
      ov_r <= fin_v;
      o_r <= fin_d;
    end
  end

  assign in_stall = sv_r;
  assign out_valid = ov_r;
  assign out_distance_cm = o_r;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hvd_pkg::*;

  localparam int STALL_LIMIT = 20000;

  class distance_scoreboard;
    longint unsigned radius_m;
    longint unsigned pending_cm[$];
    int unsigned mismatches;
    int unsigned checked;
    longint atan_tab[24] = '{
      900000000, 531301024, 280724869, 142500327, 71526687, 35798212,
      17903474, 8952283, 4476210, 2238114, 1119058, 559529, 279765, 139882,
      69941, 34971, 17485, 8743, 4371, 2186, 1093, 546, 273, 137};

    function new();
      radius_m = 6371000;
      mismatches = 0;
      checked = 0;
    endfunction

    function void rotate(input longint ang, output longint cs, output longint sn);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = ang;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      cs = x;
      sn = y;
    endfunction

    function longint vector_angle(input longint x0, input longint y0);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function longint half_sine(input longint d);
      longint h, cs, sn;
      h = (d + 64'sd1800000000) % 64'sd3600000000;
      if (h < 0) h += 64'sd3600000000;
      h -= 64'sd1800000000;
      rotate(h, cs, sn);
      return sn;
    endfunction

    function longint lat_cosine(input longint lat);
      longint t, cs, sn;
      t = lat * 2;
      if (t < 0) t = -t;
      if (t > 64'sd1800000000) begin
        rotate(64'sd3600000000 - t, cs, sn);
        return -cs;
      end
      rotate(t, cs, sn);
      return cs;
    endfunction

    function longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint unsigned distance_cm(input longint plat, input longint plon,
                                          input longint clat, input longint clon);
      longint s1, s2, cp, sq, hav, half;
      longint unsigned ua, sa, sb, prod, quo, rem, cq, cm;
      s1 = half_sine(clat - plat);
      s2 = half_sine(clon - plon);
      cp = (lat_cosine(plat) * lat_cosine(clat)) >>> 30;
      sq = (s2 * s2) >>> 30;
      hav = s1 * s1 + cp * sq;
      if (hav < 0) hav = 0;
      if (hav > (64'sd1 <<< 60)) hav = 64'sd1 <<< 60;
      ua = hav;
      sa = int_sqrt(ua);
      sb = int_sqrt((64'd1 << 60) - ua);
      half = 0;
      if (sa != 0) begin
        half = vector_angle(sb, sa);
        if (half < 0) half = 0;
        if (half > 64'sd1800000000) half = 64'sd1800000000;
      end
      prod = radius_m * half;
      quo = prod / 64'd18000000;
      rem = prod % 64'd18000000;
      cq = quo * 64'd3373259426 + (rem * 64'd3373259426) / 64'd18000000;
      cm = (cq + (64'd1 << 29)) >> 30;
      if (cm > 64'hFFFFFFFF) cm = 64'hFFFFFFFF;
      return cm;
    endfunction

    function void note_request(input longint plat, input longint plon,
                               input longint clat, input longint clon);
      pending_cm.push_back(distance_cm(plat, plon, clat, clon));
    endfunction

    function void check_result(input logic [DIST_W-1:0] got);
      longint unsigned want;
      if (pending_cm.size() == 0) begin
        $error("distance_cm: result %0d with no request outstanding", got);
        mismatches++;
        return;
      end
      want = pending_cm.pop_front();
      checked++;
      if (got !== want[DIST_W-1:0]) begin
        $error("distance_cm mismatch: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [LAT_W-1:0] in_prev_lat = '0;
  logic signed [LON_W-1:0] in_prev_lon = '0;
  logic signed [LAT_W-1:0] in_cur_lat = '0;
  logic signed [LON_W-1:0] in_cur_lon = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance_cm;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  distance_scoreboard sb = new();
  int unsigned idle_pct = 37;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;

  haversine_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_prev_lat(in_prev_lat), .in_prev_lon(in_prev_lon),
    .in_cur_lat(in_cur_lat), .in_cur_lon(in_cur_lon),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_cm(out_distance_cm),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_prev_lat, in_prev_lon, in_cur_lat, in_cur_lon);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_distance_cm);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(input logic signed [LAT_W-1:0] plat,
                              input logic signed [LON_W-1:0] plon,
                              input logic signed [LAT_W-1:0] clat,
                              input logic signed [LON_W-1:0] clon);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_prev_lat <= plat;
    in_prev_lon <= plon;
    in_cur_lat <= clat;
    in_cur_lon <= clon;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    in_valid <= 1'b0;
    while (sb.pending_cm.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 0) sb.radius_m = data[RAD_W-1:0];
  endtask

  function automatic logic signed [LAT_W-1:0] rand_lat();
    if ($urandom_range(0, 9) == 0) return LAT_W'($urandom);
    return LAT_W'(longint'($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic signed [LON_W-1:0] rand_lon();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return LON_W'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
  endfunction

  task automatic random_requests(input int n);
    logic signed [LAT_W-1:0] pl, cl;
    logic signed [LON_W-1:0] po, co;
    for (int i = 0; i < n; i++) begin
      pl = rand_lat();
      po = rand_lon();
      if ($urandom_range(0, 2) == 0) begin
        cl = pl + LAT_W'(int'($urandom_range(0, 200000)) - 100000);
        co = po + LON_W'(int'($urandom_range(0, 200000)) - 100000);
      end else begin
        cl = rand_lat();
        co = rand_lon();
      end
      send_request(pl, po, cl, co);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(0, 0, 0, 0);
    send_request(900000000, 0, -900000000, 0);
    send_request(0, 1800000000, 0, -1800000000);
    send_request(0, 0, 0, 1800000000);
    send_request(0, -1800000000, 0, 1800000000);
    send_request(450000000, 0, -450000000, 1800000000);
    send_request(1073741823, 2147483647, -1073741824, -2147483648);
    send_request(-1073741824, -2147483648, 1073741823, 2147483647);
    send_request(1000000000, 100000000, 1000000000, -100000000);
    send_request(-950000000, 0, 950000000, 1000000000);
    send_request(515000000, -1200000, 515000001, -1200000);
    send_request(-338000000, 1512000000, 407000000, -740000000);
    send_request(900000000, 1234567, 900000000, -7654321);
    random_requests(140);

    idle_pct = 0;
    random_requests(100);
    idle_pct = 37;

    write_reg(3'd4, 32'd12345);
    random_requests(20);
    write_reg(3'd0, 32'd1);
    send_request(0, 0, 0, 1800000000);
    random_requests(80);
    write_reg(3'd0, 32'd10000000);
    send_request(0, 0, 0, 1800000000);
    random_requests(100);
    write_reg(3'd0, 32'd0);
    random_requests(30);
    write_reg(3'd0, 32'hFFFFFFFF);
    send_request(0, 0, 0, 1800000000);
    send_request(900000000, 0, -900000000, 0);
    random_requests(80);
    write_reg(3'd0, $urandom_range(1, 10000000));
    random_requests(120);

    in_valid <= 1'b0;
    while (sb.pending_cm.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d position pairs and checked %0d distances", sent, sb.checked);
    $display("over six radius settings, including zero and the register maximum.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/hvd_pkg.sv
rtl/hvd_cordic.sv
rtl/hvd_isqrt.sv
rtl/haversine_distance.sv
sim/tb_top.sv
